// File: rtl/core/gmcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcp_pkg
// Shared widths, register indexes and helpers for the grid min-cost path block.
// ----------------------------------------------------------------------------
package gmcp_pkg;

    // Payload and register widths
    localparam int COST_W    = 16;
    localparam int SUM_W     = 32;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Default grid limits
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 256;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_ROWS = 2'd0,
        REG_NUM_COLS = 2'd1
    } cfg_reg_t;

    // Clamp a written dimension: zero acts as one, large values saturate
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input int maxv);
        logic [CFG_W-1:0] res;
        if (v == '0)
            res = CFG_W'(1);
        else if (int'(v) > maxv)
            res = CFG_W'(maxv);
        else
            res = v;
        return res;
    endfunction

endpackage

// File: rtl/core/gmcp_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcp_ifs
// Valid/ready channels for grid cells in and path results out.
// ----------------------------------------------------------------------------
interface gmcp_cell_if
    import gmcp_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [COST_W-1:0] cell_cost;

    modport source (output valid, output cell_cost, input ready);
    modport sink   (input valid, input cell_cost, output ready);
endinterface

interface gmcp_result_if
    import gmcp_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] min_cost;

    modport source (output valid, output min_cost, input ready);
    modport sink   (input valid, input min_cost, output ready);
endinterface

// File: rtl/core/gmcp_row_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmcp_row_mem
// One-row buffer of best totals: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gmcp_row_mem
    import gmcp_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DW    = SUM_W
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: hold the last read while no new one is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/grid_min_cost_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_cost_path
// Cheapest right/down/diagonal path cost through a streamed grid of costs.
// ----------------------------------------------------------------------------
// Usage:
//   cells  : valid/ready sink, one signed 16-bit cost per beat, row-major.
//   result : valid/ready source, one signed 32-bit min_cost beat per grid,
//            sent after the bottom-right cell.
//   cfg_we/cfg_index/cfg_data : register 0 is num_rows, register 1 is
//            num_cols. A write to either rearms the cell counters so the next
//            beat is the top-left cell of a new grid. Write only while idle.
// Throughput: one cell per cycle while no last cell waits on the output slot.
//   Each cell reads the row buffer at its column when accepted and writes its
//   total back there when it leaves the issue stage; a read that meets the
//   write of the same column in the same cycle is forwarded from the adder.
// Output: min_cost is loaded into the output register as the last cell
//   leaves the issue stage.
// Reset: counters clear, num_rows and num_cols return to one. The row buffer
//   is not cleared; the first row reads its entries but does not use them.
// Stall: the output register holds a result while result.ready is low; cells
//   keep flowing until a further last cell has to wait for that slot.
// ----------------------------------------------------------------------------
module grid_min_cost_path
    import gmcp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    gmcp_cell_if.sink            cells,
    gmcp_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCMP_W = ((COL_W > CFG_W) ? COL_W : CFG_W) + 1;
    localparam int RCMP_W = ((ROW_W > CFG_W) ? ROW_W : CFG_W) + 1;

    typedef logic signed [SUM_W-1:0] sum_t;

    // Configuration and position counters
    logic [CFG_W-1:0] num_rows_reg, num_cols_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    // Issue stage: cell waiting for its buffer read
    logic                     s1_valid_reg;
    logic signed [COST_W-1:0] s1_cost_reg;
    logic [COL_W-1:0]         s1_addr_reg;
    logic                     s1_first_row_reg;
    logic                     s1_first_col_reg;
    logic                     s1_last_reg;

    // Running neighbours and forwarding
    sum_t left_reg, upleft_reg;
    logic fwd_valid_reg;
    sum_t fwd_data_reg;

    // Output register
    logic out_valid_reg;
    sum_t out_data_reg;

    logic [SUM_W-1:0] rd_data;
    logic             accept, exec, exec_last;
    logic             last_col, last_row;
    sum_t             up, min_lu, min3, base, cost_ext, best;

    // Handshake
    assign exec      = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result.ready);
    assign exec_last = exec && s1_last_reg;
    assign cells.ready = !s1_valid_reg || exec;
    assign accept    = cells.valid && cells.ready;

    assign result.valid    = out_valid_reg;
    assign result.min_cost = out_data_reg;

    // Position of the incoming cell
    assign last_col = (CCMP_W'(col_reg) + CCMP_W'(1)) >= CCMP_W'(num_cols_reg);
    assign last_row = (RCMP_W'(row_reg) + RCMP_W'(1)) >= RCMP_W'(num_rows_reg);

    // Best total of this cell
    assign cost_ext = sum_t'({{(SUM_W-COST_W){s1_cost_reg[COST_W-1]}}, s1_cost_reg});
    assign up       = fwd_valid_reg ? fwd_data_reg : sum_t'(rd_data);
    assign min_lu   = (upleft_reg < up) ? upleft_reg : up;
    assign min3     = (min_lu < left_reg) ? min_lu : left_reg;

    always_comb
    begin
        if (s1_first_row_reg && s1_first_col_reg)
            base = '0;
        else if (s1_first_row_reg)
            base = left_reg;
        else if (s1_first_col_reg)
            base = up;
        else
            base = min3;
    end

    assign best = base + cost_ext;

    // Row buffer
    gmcp_row_mem #(
        .DEPTH (MAX_COLS),
        .AW    (COL_W),
        .DW    (SUM_W)
    ) u_row_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (exec),
        .wr_addr (s1_addr_reg),
        .wr_data (best)
    );

    // Configuration registers and cell counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= CFG_W'(1);
            num_cols_reg <= CFG_W'(1);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (cfg_we && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS))
        begin
            if (cfg_index == REG_NUM_ROWS)
                num_rows_reg <= clamp_dim(cfg_data, MAX_ROWS);
            else
                num_cols_reg <= clamp_dim(cfg_data, MAX_COLS);
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // Issue stage: take a beat, hold it while the output slot is busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s1_cost_reg      <= '0;
            s1_addr_reg      <= '0;
            s1_first_row_reg <= 1'b0;
            s1_first_col_reg <= 1'b0;
            s1_last_reg      <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            fwd_data_reg     <= '0;
        end
        else if (accept)
        begin
            s1_valid_reg     <= 1'b1;
            s1_cost_reg      <= cells.cell_cost;
            s1_addr_reg      <= col_reg;
            s1_first_row_reg <= (row_reg == '0);
            s1_first_col_reg <= (col_reg == '0);
            s1_last_reg      <= last_col && last_row;
            fwd_valid_reg    <= exec && (s1_addr_reg == col_reg);
            fwd_data_reg     <= best;
        end
        else if (exec)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Neighbour totals and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            upleft_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (exec)
            begin
                left_reg   <= best;
                upleft_reg <= up;
            end
            if (exec_last)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= best;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A new result only follows the final cell of a grid
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(exec_last))
        else $error("result raised without a final cell");

    // Column counter stays inside the grid
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CCMP_W'(col_reg) < CCMP_W'(num_cols_reg))
        else $error("column counter beyond num_cols");

    // A held cell keeps its buffer read data, unwritten entries included
    a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(s1_valid_reg) && !$past(exec) && s1_valid_reg)
            |-> (rd_data === $past(rd_data)))
        else $error("row buffer data lost during stall");
`endif

endmodule

// File: test/grid_min_cost_path_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_cost_path_checker
// Watches the cell, result and register ports of the grid min-cost path block,
// keeps its own running path totals and checks every min_cost beat in order.
// ----------------------------------------------------------------------------
module grid_min_cost_path_checker
    import gmcp_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    gmcp_cell_if                 cells,
    gmcp_result_if               result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   outstanding,
    output int                   results_checked
);

    typedef logic signed [SUM_W-1:0] total_t;

    // Running totals of the grid in flight
    total_t      row_totals [MAX_COLS];
    total_t      left_total;
    total_t      upleft_total;
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned rows_eff;
    int unsigned cols_eff;
    total_t      expected_min_costs [$];
    total_t      wanted_cost;

    // Effective grid size for a written value: zero means one, saturate above
    function automatic int unsigned limit_dim(input logic [CFG_W-1:0] value,
                                              input int unsigned ceiling);
        int unsigned size;
        size = value;
        if (size == 0)
            size = 1;
        else if (size > ceiling)
            size = ceiling;
        return size;
    endfunction

    function automatic total_t least_of(input total_t a, input total_t b, input total_t c);
        total_t m;
        m = (b < a) ? b : a;
        return (c < m) ? c : m;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Fold one cell into the totals; queue the path cost after the last cell
    task automatic advance_path_totals(input logic signed [COST_W-1:0] cost);
        total_t cost_ext;
        total_t above;
        total_t total;
        cost_ext = cost;
        above    = row_totals[col_pos];
        if (row_pos == 0 && col_pos == 0)
            total = cost_ext;
        else if (row_pos == 0)
            total = left_total + cost_ext;
        else if (col_pos == 0)
            total = above + cost_ext;
        else
            total = least_of(left_total, above, upleft_total) + cost_ext;
        upleft_total        = above;
        left_total          = total;
        row_totals[col_pos] = total;
        if (col_pos + 1 >= cols_eff)
        begin
            col_pos = 0;
            if (row_pos + 1 >= rows_eff)
            begin
                row_pos = 0;
                expected_min_costs.push_back(total);
            end
            else
            begin
                row_pos++;
            end
        end
        else
        begin
            col_pos++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (row_totals[i])
                row_totals[i] = '0;
            left_total      = '0;
            upleft_total    = '0;
            row_pos         = 0;
            col_pos         = 0;
            rows_eff        = 1;
            cols_eff        = 1;
            expected_min_costs.delete();
            outstanding     = 0;
            fail_count      = 0;
            results_checked = 0;
        end
        else
        begin
            // Track register writes; a size write rearms the grid position
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_ROWS:
                    begin
                        rows_eff = limit_dim(cfg_data, MAX_ROWS);
                        row_pos  = 0;
                        col_pos  = 0;
                    end
                    REG_NUM_COLS:
                    begin
                        cols_eff = limit_dim(cfg_data, MAX_COLS);
                        row_pos  = 0;
                        col_pos  = 0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Check the result beat against the oldest queued path cost
            if (result.valid && result.ready)
            begin
                if (expected_min_costs.size() == 0)
                begin
                    report_mismatch($sformatf("min_cost %0d with no grid finished",
                                              result.min_cost));
                end
                else
                begin
                    wanted_cost = expected_min_costs.pop_front();
                    if (result.min_cost !== wanted_cost)
                        report_mismatch($sformatf("min_cost %0d, expected %0d",
                                                  result.min_cost, wanted_cost));
                    results_checked++;
                end
            end

            // Advance the totals on each cell beat
            if (cells.valid && cells.ready)
                advance_path_totals(cells.cell_cost);

            outstanding = expected_min_costs.size();
        end
    end

endmodule

// File: test/grid_min_cost_path_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_cost_path_test
// Streams grids of signed costs into the min-cost path block under a series
// of grid sizes, with random gaps on both channels, and reports the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module grid_min_cost_path_test
    import gmcp_pkg::*;
();

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 6;
    localparam int RANDOM_CELLS = 1150;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_GAP      = 8;

    // Register indexes past the end of the register file
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

    localparam logic signed [COST_W-1:0] COST_TOP    = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_BOTTOM = {1'b1, {(COST_W-1){1'b0}}};

    typedef enum int {COST_FULL, COST_EDGE, COST_TIES} cost_mix_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   outstanding;
    int                   results_checked;
    int                   cycle_count = 0;
    int                   cells_sent  = 0;
    int                   reg_writes  = 0;
    int                   phases      = 0;
    bit                   quiet       = 1'b0;

    gmcp_cell_if   cells ();
    gmcp_result_if result ();

    grid_min_cost_path u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cells     (cells),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    grid_min_cost_path_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cells           (cells),
        .result          (result),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial clk = 1'b0;
    always #(HALF_PERIOD) clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, outstanding);
            $display("FAIL");
            $finish;
        end
    end

    // Wait before a beat: often none, otherwise a random wait bounded by MAX_GAP
    function automatic int draw_wait();
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic signed [COST_W-1:0] draw_cost(input cost_mix_t mix);
        logic signed [COST_W-1:0] cost;
        case (mix)
            COST_EDGE:
            begin
                case ($urandom_range(0, 2))
                    0:       cost = COST_TOP;
                    1:       cost = COST_BOTTOM;
                    default: cost = COST_W'($urandom);
                endcase
            end
            COST_TIES: cost = COST_W'(int'($urandom_range(0, 6)) - 3);
            default:   cost = COST_W'($urandom);
        endcase
        return cost;
    endfunction

    // Drive one cell beat and hold it until accepted
    task automatic send_cell(input logic signed [COST_W-1:0] cost);
        int gap;
        bit taken;
        gap = draw_wait();
        if (gap != 0)
        begin
            cells.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cells.valid     <= 1'b1;
        cells.cell_cost <= cost;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cells.ready;
            @(posedge clk);
        end
        cells_sent++;
    endtask

    // Drop valid, wait for every due result, then let the pipeline drain
    task automatic wait_idle();
        cells.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        reg_writes++;
    endtask

    task automatic close_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        phases++;
    endtask

    // Write a grid size, sometimes as a value the block has to clamp
    task automatic write_dim(input cfg_reg_t which, input int size, input int ceiling);
        logic [CFG_W-1:0] value;
        value = CFG_W'(size);
        if (size == 1 && $urandom_range(0, 2) == 0)
            value = '0;
        else if (size == ceiling && $urandom_range(0, 1) == 0)
            value = CFG_W'($urandom_range(ceiling, 2**CFG_W - 1));
        write_reg(which, value);
    endtask

    // Result side: stall for a drawn number of cycles, then take one beat
    initial
    begin : result_drain
        int  stall;
        bit  took;
        result.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall != 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            took = 1'b0;
            while (!took)
            begin
                @(negedge clk);
                took = result.valid;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int        rows;
        int        cols;
        int        grid_cells;
        int        beats;
        int        random_start;
        int        phase_no;
        cost_mix_t mix;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_NUM_ROWS;
        cfg_data        <= '0;
        cells.valid     <= 1'b0;
        cells.cell_cost <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-cell grids at the reset size, cost extremes
        send_cell(COST_TOP);
        send_cell(COST_BOTTOM);
        send_cell('0);

        // Zero sizes act as one
        wait_idle();
        write_reg(REG_NUM_ROWS, '0);
        write_reg(REG_NUM_COLS, '0);
        close_writes();
        send_cell(-16'sd1);

        // Ignored indexes, then a 2x3 grid over edge, column and diagonal moves
        wait_idle();
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '0);
        write_reg(REG_NUM_ROWS, 9'd2);
        write_reg(REG_NUM_COLS, 9'd3);
        close_writes();
        send_cell(16'sd5);
        send_cell(COST_BOTTOM);
        send_cell(16'sd7);
        send_cell(COST_TOP);
        send_cell(-16'sd2);
        send_cell(16'sd1);

        // Abandon a 3x2 grid part way and rearm with a single register write
        wait_idle();
        write_reg(REG_NUM_ROWS, 9'd3);
        write_reg(REG_NUM_COLS, 9'd2);
        close_writes();
        send_cell(16'sd10);
        send_cell(16'sd20);
        send_cell(-16'sd5);
        wait_idle();
        write_reg(REG_NUM_COLS, 9'd2);
        close_writes();
        send_cell(16'sd0);
        send_cell(-16'sd1);
        send_cell(-16'sd1);
        send_cell(16'sd0);
        send_cell(16'sd0);
        send_cell(-16'sd1);

        // Random phases: tallest and widest grids first, then small ones
        rows         = 3;
        cols         = 2;
        random_start = cells_sent;
        phase_no     = 0;
        while (cells_sent - random_start < RANDOM_CELLS)
        begin
            wait_idle();
            quiet = ($urandom_range(0, 3) == 0);
            mix   = cost_mix_t'($urandom_range(0, 2));
            if (phase_no >= 2 && rows * cols <= 64 && $urandom_range(0, 4) == 0)
            begin
                // Ignored write mid-grid: the position must carry on
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          CFG_W'($urandom));
                close_writes();
                beats = $urandom_range(1, 2 * rows * cols);
            end
            else
            begin
                if (phase_no == 0)
                begin
                    rows = DEF_MAX_ROWS;
                    cols = 1;
                end
                else if (phase_no == 1)
                begin
                    rows = 2;
                    cols = DEF_MAX_COLS;
                end
                else
                begin
                    rows = $urandom_range(1, 6);
                    cols = $urandom_range(1, 8);
                end
                if ($urandom_range(0, 1))
                begin
                    write_dim(REG_NUM_ROWS, rows, DEF_MAX_ROWS);
                    write_dim(REG_NUM_COLS, cols, DEF_MAX_COLS);
                end
                else
                begin
                    write_dim(REG_NUM_COLS, cols, DEF_MAX_COLS);
                    write_dim(REG_NUM_ROWS, rows, DEF_MAX_ROWS);
                end
                close_writes();
                grid_cells = rows * cols;
                if (grid_cells > 64)
                begin
                    beats = grid_cells;
                end
                else
                begin
                    beats = grid_cells * $urandom_range(1, 4);
                    // Leave a broken grid behind for the next rearm
                    if (grid_cells > 1 && $urandom_range(0, 4) == 0)
                        beats += $urandom_range(1, grid_cells - 1);
                end
            end
            repeat (beats) send_cell(draw_cost(mix));
            phase_no++;
        end

        wait_idle();
        $display("%0d cell beats over %0d register phases, %0d register writes",
                 cells_sent, phases, reg_writes);
        $display("%0d min_cost results checked, %0d mismatches",
                 results_checked, fail_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/core/gmcp_pkg.sv
rtl/core/gmcp_ifs.sv
rtl/core/gmcp_row_mem.sv
rtl/core/grid_min_cost_path.sv
test/grid_min_cost_path_checker.sv
test/grid_min_cost_path_test.sv
